[hdl/ipv4p_pkg.sv]
// ----------------------------------------------------------------------------
// IPv4 dotted-quad parser package
// Shared constants, types and helper functions for the parser modules.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

  // Width of the internal character counter; the count saturates at its top.
  localparam int LengthBits = 16;
  // Width of the length field in a result.
  localparam int OutLenBits = 16;

  // Character codes that the parser recognises.
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharLBrack = 8'h5B;
  localparam logic [7:0] CharRBrack = 8'h5D;

  // Index of the last of the four numbers.
  localparam logic [1:0] LastOctet = 2'd3;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_DIGIT,
    PH_NUMBER,
    PH_DONE
  } phase_t;

  // One input item held in the input register.
  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } item_t;

  // One result item.
  typedef struct packed {
    logic                  ok;
    logic [31:0]           address;
    logic [OutLenBits-1:0] length;
  } result_t;

  // Counter increment that sticks at the all-ones value.
  function automatic logic [LengthBits-1:0] count_up(input logic [LengthBits-1:0] c);
    logic [LengthBits-1:0] r;
    r = c;
    if (c != {LengthBits{1'b1}}) begin
      r = c + LengthBits'(1);
    end
    return r;
  endfunction

  // Clip the internal count to the width of the length field.
  function automatic logic [OutLenBits-1:0] clip_length(input logic [LengthBits-1:0] c);
    logic [32:0] wide;
    logic [OutLenBits-1:0] r;
    wide = 33'(c);
    if (wide > 33'({OutLenBits{1'b1}})) begin
      r = {OutLenBits{1'b1}};
    end else begin
      r = wide[OutLenBits-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/ipv4_dotted_quad_parser_unit.sv]
// ----------------------------------------------------------------------------
// IPv4 dotted-quad parser
// Parses one character per transfer into a 32-bit address and its length.
//
//   Channel   Direction  Contents
//   s_*       in         tdata: ch [7:0]; tuser: start_req [0]
//   m_*       out        tdata: address [31:0], length [47:32]; tuser: ok [0]
//   cfg_*     in         cfg_data: bracket_mode [0]
//
// One character is accepted per cycle unless a stalled result holds it up;
// each passes through an input register and a result register.
// The parse itself is a single combinational update between them.
// A stalled result holds the parse stage; an empty input register still
// takes one more character. Synchronous reset empties both registers and
// puts the parser in the state expecting the first character.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser_unit import ipv4p_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] address, [47:32] length
  output logic        m_tuser,   // [0] ok
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic    bracket_mode;
  logic    advance;
  logic    held_valid;
  item_t   in_item;
  item_t   held_item;
  logic    step;
  logic    emit;
  result_t res;

  // Configuration register; always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bracket_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      bracket_mode <= cfg_data;
    end
  end

  assign in_item.ch        = s_tdata;
  assign in_item.start_req = s_tuser;
  assign step              = held_valid && advance;

  ipv4p_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .in_item    (in_item),
    .take       (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ipv4p_core u_core (
    .clk          (clk),
    .rst          (rst),
    .bracket_mode (bracket_mode),
    .step         (step),
    .item         (held_item),
    .emit         (emit),
    .res          (res)
  );

  ipv4p_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (emit),
    .res      (res),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

[hdl/ipv4p_in_reg.sv]
// ----------------------------------------------------------------------------
// IPv4 parser input register
// Holds one received character until the parse stage consumes it.
// ----------------------------------------------------------------------------
module ipv4p_in_reg import ipv4p_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  item_t in_item,
  input  logic  take,      // parse stage consumes the held item this cycle
  output logic  held_valid,
  output item_t held_item
);

  // The register may load when it is empty or is being emptied.
  assign s_tready = !held_valid || take;

  // Valid flag of the held item.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  // Payload of the held item.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_item <= in_item;
    end
  end

endmodule

[hdl/ipv4p_core.sv]
// ----------------------------------------------------------------------------
// IPv4 parser core
// Parser state and the update for one character.
// ----------------------------------------------------------------------------
module ipv4p_core import ipv4p_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    bracket_mode,
  input  logic    step,      // a character is processed this cycle
  input  item_t   item,
  output logic    emit,      // the character finishes a string
  output result_t res
);

  phase_t                phase, phase_next;
  logic [1:0]            octet_index, octet_index_next;
  logic [7:0]            accumulator, accumulator_next;
  logic [31:0]           address_so_far, address_so_far_next;
  logic [LengthBits-1:0] consumed_count, consumed_count_next;
  logic                  mode_latched, mode_latched_next;

  phase_t                eff_phase;
  logic                  is_first;
  logic                  is_digit;
  logic [7:0]            digit;
  logic [7:0]            acc_times_ten;
  logic [31:0]           address_shifted;

  // Character decode and the phase after an optional restart.
  assign eff_phase       = item.start_req ? PH_FIRST : phase;
  assign is_first        = (eff_phase == PH_FIRST);
  assign is_digit        = (item.ch >= CharZero) && (item.ch <= CharNine);
  assign digit           = item.ch - CharZero;
  assign acc_times_ten   = {accumulator[4:0], 3'b000} + {accumulator[6:0], 1'b0};
  assign address_shifted = {address_so_far[23:0], accumulator};

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (step) begin
      unique case (eff_phase)
        PH_FIRST: begin
          if (bracket_mode) begin
            phase_next = (item.ch == CharLBrack) ? PH_DIGIT : PH_DONE;
          end else begin
            phase_next = is_digit ? PH_NUMBER : PH_DONE;
          end
        end
        PH_DIGIT: begin
          phase_next = is_digit ? PH_NUMBER : PH_DONE;
        end
        PH_NUMBER: begin
          if (is_digit) begin
            phase_next = PH_NUMBER;
          end else if (octet_index != LastOctet && item.ch == CharDot) begin
            phase_next = PH_DIGIT;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  // Datapath updates and the result of a finished string.
  always_comb begin
    octet_index_next    = octet_index;
    accumulator_next    = accumulator;
    address_so_far_next = address_so_far;
    consumed_count_next = consumed_count;
    mode_latched_next   = mode_latched;
    emit                = 1'b0;
    res                 = '0;
    if (step && eff_phase != PH_DONE) begin
      // A new string starts from cleared state with the current mode.
      if (is_first) begin
        mode_latched_next   = bracket_mode;
        octet_index_next    = '0;
        accumulator_next    = '0;
        address_so_far_next = '0;
        consumed_count_next = '0;
      end
      priority if (is_first && bracket_mode) begin
        // Opening bracket is required.
        if (item.ch != CharLBrack) begin
          emit = 1'b1;
        end else begin
          consumed_count_next = count_up('0);
        end
      end else if (is_first || eff_phase == PH_DIGIT) begin
        // Each number needs a leading digit.
        if (!is_digit) begin
          emit = 1'b1;
        end else begin
          accumulator_next    = digit;
          consumed_count_next = count_up(is_first ? '0 : consumed_count);
        end
      end else if (is_digit) begin
        // Further digits accumulate modulo 256.
        accumulator_next    = acc_times_ten + digit;
        consumed_count_next = count_up(consumed_count);
      end else begin
        // A non-digit closes the current number.
        address_so_far_next = address_shifted;
        if (octet_index != LastOctet) begin
          if (item.ch != CharDot) begin
            emit = 1'b1;
          end else begin
            consumed_count_next = count_up(consumed_count);
            octet_index_next    = octet_index + 2'd1;
            accumulator_next    = '0;
          end
        end else if (mode_latched) begin
          emit = 1'b1;
          if (item.ch == CharRBrack) begin
            consumed_count_next = count_up(consumed_count);
            res.ok      = 1'b1;
            res.address = address_shifted;
            res.length  = clip_length(count_up(consumed_count));
          end
        end else begin
          emit        = 1'b1;
          res.ok      = 1'b1;
          res.address = address_shifted;
          res.length  = clip_length(consumed_count);
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_FIRST;
      octet_index    <= '0;
      accumulator    <= '0;
      address_so_far <= '0;
      consumed_count <= '0;
      mode_latched   <= 1'b0;
    end else begin
      phase          <= phase_next;
      octet_index    <= octet_index_next;
      accumulator    <= accumulator_next;
      address_so_far <= address_so_far_next;
      consumed_count <= consumed_count_next;
      mode_latched   <= mode_latched_next;
    end
  end

endmodule

[hdl/ipv4p_out_reg.sv]
// ----------------------------------------------------------------------------
// IPv4 parser result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ipv4p_out_reg import ipv4p_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  result_t      res,
  output logic         advance,  // register can take a new result this cycle
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,  // [31:0] address, [47:32] length
  output logic         m_tuser   // [0] ok
);

  result_t held;

  assign advance = !m_tvalid || m_tready;

  // Valid flag of the held result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= load;
    end
  end

  // Payload of the held result.
  always_ff @(posedge clk) begin
    if (load && advance) begin
      held <= res;
    end
  end

  assign m_tdata = {held.length, held.address};
  assign m_tuser = held.ok;

endmodule

[hdl/ipv4p_checker.sv]
// ----------------------------------------------------------------------------
// IPv4 parser port checker
// Concurrent checks on the top-level ports, bound to the parser.
// ----------------------------------------------------------------------------
module ipv4p_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  // No result is offered in the cycle after reset.
  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered straight after reset");

  // A stalled result keeps its contents.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // A failed parse reports a zero address and zero length.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 48'd0)
    else $error("failed parse carries a non-zero payload");

  // The shortest valid address text has seven characters.
  a_ok_min_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[47:32] >= 16'd7)
    else $error("successful parse with impossible length");

endmodule

bind ipv4_dotted_quad_parser_unit ipv4p_checker u_ipv4p_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[bench/ipv4_parse_checker.sv]
// ----------------------------------------------------------------------------
// IPv4 dotted-quad parser checker
// Watches the character, result and configuration channels of the parser.
// Every accepted character is run through an independent model of the parse.
// Each result it produces is queued. Every result transfer from the block is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module ipv4_parse_checker import ipv4p_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] start_req
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // [31:0] address, [47:32] length
  input  logic        m_tuser,   // [0] ok
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,  // [0] bracket_mode
  output int          n_errors,
  output int          n_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  // Parser state as the block should hold it.
  phase_t                phase_q;
  logic [1:0]            octet_q;
  logic [7:0]            acc_q;
  logic [31:0]           addr_q;
  logic [LengthBits-1:0] count_q;
  logic                  mode_q;
  logic                  bracket_reg;

  // Results predicted but not yet seen on the output channel.
  result_t pending_results[$];

  // Counter increment that sticks at its top value.
  function automatic void bump_count();
    if (count_q != {LengthBits{1'b1}}) begin
      count_q = count_q + 1'b1;
    end
  endfunction

  // Closes the current string and returns the result that it produces.
  function automatic result_t close_string(input bit good);
    result_t         r;
    longint unsigned wide;
    wide = longint'(count_q);
    r.ok = good;
    r.address = good ? addr_q : 32'd0;
    if (!good) begin
      r.length = '0;
    end else if (wide > longint'({OutLenBits{1'b1}})) begin
      r.length = '1;
    end else begin
      r.length = OutLenBits'(wide);
    end
    phase_q = PH_DONE;
    return r;
  endfunction

  // Advances the parse by one character; sets emitted when a string ends.
  task automatic advance_parser(input logic [7:0] c, input logic st,
                                output bit emitted, output result_t r);
    bit is_digit;
    is_digit = (c >= CharZero) && (c <= CharNine);
    emitted = 1'b0;
    r = '0;
    if (st) begin
      phase_q = PH_FIRST;
    end
    if (phase_q == PH_DONE) begin
      return;
    end
    // Opening character: latch the mode and clear the address.
    if (phase_q == PH_FIRST) begin
      mode_q  = bracket_reg;
      octet_q = '0;
      acc_q   = '0;
      addr_q  = '0;
      count_q = '0;
      phase_q = PH_DIGIT;
      if (mode_q) begin
        if (c != CharLBrack) begin
          emitted = 1'b1;
          r = close_string(1'b0);
        end else begin
          bump_count();
        end
        return;
      end
    end
    // A number must open with a digit.
    if (phase_q == PH_DIGIT) begin
      if (!is_digit) begin
        emitted = 1'b1;
        r = close_string(1'b0);
      end else begin
        acc_q = c - CharZero;
        bump_count();
        phase_q = PH_NUMBER;
      end
      return;
    end
    // Inside a number: further digits accumulate modulo 256.
    if (is_digit) begin
      acc_q = 8'((acc_q * 10) + (c - CharZero));
      bump_count();
      return;
    end
    addr_q = {addr_q[23:0], acc_q};
    if (octet_q != LastOctet) begin
      if (c != CharDot) begin
        emitted = 1'b1;
        r = close_string(1'b0);
      end else begin
        bump_count();
        octet_q = octet_q + 1'b1;
        acc_q = '0;
        phase_q = PH_DIGIT;
      end
      return;
    end
    // Fourth number finished: in bracket mode the closing bracket must follow.
    emitted = 1'b1;
    if (mode_q && (c != CharRBrack)) begin
      r = close_string(1'b0);
    end else begin
      if (mode_q) begin
        bump_count();
      end
      r = close_string(1'b1);
    end
  endtask

  // Sampling at each rising edge: results are checked before new characters.
  always @(posedge clk) begin
    bit      emitted;
    result_t predicted;
    result_t seen;
    if (rst) begin
      phase_q     = PH_FIRST;
      octet_q     = '0;
      acc_q       = '0;
      addr_q      = '0;
      count_q     = '0;
      mode_q      = 1'b0;
      bracket_reg = 1'b0;
      n_errors    = 0;
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.ok      = m_tuser;
        seen.address = m_tdata[31:0];
        seen.length  = m_tdata[47:32];
        if (pending_results.size() == 0) begin
          $error("Result with no expectation waiting: ok %0d address %h length %0d",
                 seen.ok, seen.address, seen.length);
          n_errors++;
        end else begin
          predicted = pending_results.pop_front();
          if (seen.ok !== predicted.ok) begin
            $error("ok mismatch: expected %0d, got %0d", predicted.ok, seen.ok);
            n_errors++;
          end
          if (seen.address !== predicted.address) begin
            $error("address mismatch: expected %h, got %h",
                   predicted.address, seen.address);
            n_errors++;
          end
          if (seen.length !== predicted.length) begin
            $error("length mismatch: expected %0d, got %0d",
                   predicted.length, seen.length);
            n_errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        bracket_reg = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        advance_parser(s_tdata, s_tuser, emitted, predicted);
        if (emitted) begin
          pending_results.push_back(predicted);
        end
      end
    end
    n_waiting = pending_results.size();
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// IPv4 dotted-quad parser testbench
// Drives character strings into the parser in plain and bracket mode: a few
// directed strings and many random strings, mostly well formed. Both
// channels idle at random in the first two of three phases. The checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb import ipv4p_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is abandoned.
  localparam int IdleLimit = 2000;
  // Cycles to wait after the results drain before a mode change; the end wait derives from it.
  localparam int PipeDepth = 4;

  typedef enum int {
    MUT_REPLACE,
    MUT_DROP,
    MUT_CUT
  } mutation_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] ch
  logic        s_tuser = 1'b0;   // [0] start_req
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;          // [31:0] address, [47:32] length
  logic        m_tuser;          // [0] ok
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;  // [0] bracket_mode

  int n_errors;
  int n_waiting;
  int n_items = 0;
  int src_idle = 0;
  int dst_idle = 0;
  int stall_cycles = 0;
  logic cur_mode = 1'b0;

  always #5 clk = ~clk;

  ipv4_dotted_quad_parser_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ipv4_parse_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .n_errors  (n_errors),
    .n_waiting (n_waiting)
  );

  // Result receiver: stalls at random according to the current phase.
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= dst_idle);
  end

  // Watchdog on cycles in which nothing is transferred.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Holds the character channel idle until every predicted result is out.
  task automatic wait_results_drained();
    s_tvalid = 1'b0;
    while (n_waiting != 0) @(negedge clk);
  endtask

  // One character transfer, after a random gap; called at a falling edge.
  task automatic send_char(input logic [7:0] c, input logic st);
    if ($urandom_range(299) == 0) begin
      wait_results_drained();
    end
    while ($urandom_range(99) < src_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = c;
    s_tuser  = st;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    n_items++;
  endtask

  task automatic send_text(input string text, input logic first_start);
    for (int i = 0; i < text.len(); i++) begin
      send_char(text[i], (i == 0) ? first_start : 1'b0);
    end
  endtask

  // Mode change only once the parser is idle and its pipeline is empty.
  task automatic write_mode(input logic m);
    wait_results_drained();
    repeat (PipeDepth) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_mode  = m;
  endtask

  function automatic logic [7:0] rand_nondigit();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c >= CharZero && c <= CharNine);
    return c;
  endfunction

  // A random string: mostly a well-formed address, some broken, some noise.
  task automatic send_random_string();
    logic [7:0] text_q[$];
    int         kind;
    int         ndig;
    int         pos;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      if (cur_mode) begin
        text_q.push_back(CharLBrack);
      end
      for (int i = 0; i < 4; i++) begin
        ndig = ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 7);
        repeat (ndig) text_q.push_back(CharZero + 8'($urandom_range(9)));
        if (i < 3) begin
          text_q.push_back(CharDot);
        end
      end
      if (cur_mode) begin
        text_q.push_back(CharRBrack);
      end
      text_q.push_back(($urandom_range(3) == 0) ? 8'h00 : rand_nondigit());
      // Broken strings: one character changed or lost, or the string cut short.
      if (kind < 40) begin
        pos = $urandom_range(text_q.size() - 1);
        case (mutation_e'($urandom_range(2)))
          MUT_REPLACE: text_q[pos] = 8'($urandom_range(255));
          MUT_DROP:    text_q.delete(pos);
          default: begin
            while (text_q.size() > pos) void'(text_q.pop_back());
          end
        endcase
      end
    end
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], (i == 0) ? ((kind < 10) ? 1'($urandom_range(1)) : 1'b1)
                                    : 1'b0);
    end
    // Trailing characters without a start are ignored once a result is out.
    repeat ($urandom_range(2)) send_char(8'($urandom_range(255)), 1'b0);
  endtask

  // One idling phase, half in plain mode and half in bracket mode.
  task automatic run_random_phase(input int src_pct, input int dst_pct, input int count);
    int goal;
    src_idle = src_pct;
    dst_idle = dst_pct;
    write_mode(1'b0);
    goal = n_items + count / 2;
    while (n_items < goal) send_random_string();
    write_mode(1'b1);
    goal = n_items + count / 2;
    while (n_items < goal) send_random_string();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Plain mode from reset; the very first character carries no start flag.
    send_text("0.0.0.0", 1'b0);
    send_char(8'h00, 1'b0);
    send_text("255.255.255.255", 1'b1);
    send_char(8'hFF, 1'b0);
    send_text("x", 1'b0);
    send_text(".", 1'b1);
    send_text("1,", 1'b1);
    // A start in the middle of a string drops it without a result.
    send_text("12.3", 1'b1);
    send_text("256.9.8.7.", 1'b1);

    // Bracket mode: good, missing opening and missing closing bracket.
    write_mode(1'b1);
    send_text("[1.2.3.4]", 1'b1);
    send_text("7", 1'b1);
    send_text("[9.9.9.9)", 1'b1);

    run_random_phase(22, 86, 470);
    run_random_phase(86, 22, 470);
    run_random_phase(0, 0, 460);

    wait_results_drained();
    repeat (4 * PipeDepth) @(negedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ipv4p_pkg.sv
hdl/ipv4p_in_reg.sv
hdl/ipv4p_core.sv
hdl/ipv4p_out_reg.sv
hdl/ipv4_dotted_quad_parser_unit.sv
hdl/ipv4p_checker.sv
bench/ipv4_parse_checker.sv
bench/tb.sv
